[hw/rtl/isms_pkg.sv]
// ----------------------------------------------------------------------------
// isms_pkg
// Shared types and constants of the Ising Metropolis site update block.
// ----------------------------------------------------------------------------
package isms_pkg;

   localparam int COORD_W   = 6;   // row and column field width
   localparam int TOSS_W    = 16;  // Q0.16 random toss
   localparam int THR_W     = 16;  // Q0.16 acceptance threshold
   localparam int NUM_THR   = 10;  // entries of the acceptance table
   localparam int THR_IDX_W = 4;
   localparam int UPS_W     = 3;   // up-neighbour count, 0..4
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 64;

   // Entries for a current +1 spin start after the five entries for -1.
   localparam logic [THR_IDX_W-1:0] THR_UP_BASE = 4'd5;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_TRIAL = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_MID  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_HIGH = 2'd2;

   typedef logic [NUM_THR-1:0][THR_W-1:0] thr_table_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_UP,
      ST_RD_DN,
      ST_RD_CTR,
      ST_CAPT,
      ST_DECIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             spin;
      logic             accepted;
      logic [UPS_W-1:0] up_neighbours;
   } result_type;

endpackage

[hw/rtl/isms_channels.sv]
// ----------------------------------------------------------------------------
// isms channels
// Valid/ready channel interfaces for requests and responses.
// ----------------------------------------------------------------------------
interface isms_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   operation;
   logic [isms_pkg::COORD_W-1:0] row;
   logic [isms_pkg::COORD_W-1:0] column;
   logic                         spin_value;
   logic [isms_pkg::TOSS_W-1:0]  toss;

   modport source (output valid, operation, row, column, spin_value, toss, input ready);
   modport sink   (input valid, operation, row, column, spin_value, toss, output ready);
endinterface

interface isms_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       spin;
   logic                       accepted;
   logic [isms_pkg::UPS_W-1:0] up_neighbours;

   modport source (output valid, spin, accepted, up_neighbours, input ready);
   modport sink   (input valid, spin, accepted, up_neighbours, output ready);
endinterface

[hw/rtl/isms_lattice_mem.sv]
// ----------------------------------------------------------------------------
// isms_lattice_mem
// Row memory of the spin torus: one synchronous read and one write per cycle.
// A row that was never written since reset reads as all -1 spins.
// ----------------------------------------------------------------------------
module isms_lattice_mem #(
   parameter int LATTICE_SIZE = 64,
   parameter int IDX_W        = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [IDX_W-1:0]        rd_addr,
   output logic [LATTICE_SIZE-1:0] rd_row,
   input  logic                    wr_en,
   input  logic [IDX_W-1:0]        wr_addr,
   input  logic [LATTICE_SIZE-1:0] wr_row
);

   logic [LATTICE_SIZE-1:0] rows_mem [LATTICE_SIZE];
   logic [LATTICE_SIZE-1:0] row_valid_ff;
   logic [LATTICE_SIZE-1:0] rd_data_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rows_mem[wr_addr] <= wr_row;
      end
      rd_data_ff <= rows_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

endmodule

[hw/rtl/isms_trial_ctrl.sv]
// ----------------------------------------------------------------------------
// isms_trial_ctrl
// Sequencer that reads the three rows around a site one at a time, counts
// up-spin neighbours in a shared accumulator and decides the Metropolis trial.
// ----------------------------------------------------------------------------
module isms_trial_ctrl #(
   parameter int LATTICE_SIZE = 64,
   parameter int IDX_W        = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   isms_req_if.sink                req_bus,
   input  isms_pkg::thr_table_type thr_table,
   output logic [IDX_W-1:0]        rd_addr,
   input  logic [LATTICE_SIZE-1:0] rd_row,
   output logic                    wr_en,
   output logic [IDX_W-1:0]        wr_addr,
   output logic [LATTICE_SIZE-1:0] wr_row,
   output logic                    res_valid,
   input  logic                    res_ready,
   output isms_pkg::result_type    res
);

   localparam logic [IDX_W-1:0] LAST = IDX_W'(LATTICE_SIZE - 1);

   isms_pkg::state_type state_ff, state_in;

   logic [1:0]                    op_ff;
   logic [IDX_W-1:0]              r_ff, c_ff;
   logic                          val_ff;
   logic [isms_pkg::TOSS_W-1:0]   toss_ff;
   logic [isms_pkg::UPS_W-1:0]    cnt_ff, cnt_in;
   logic                          cur_ff;
   logic [LATTICE_SIZE-1:0]       row_ff;
   logic                          spin_ff, spin_in;
   logic                          acc_ff, acc_in;

   logic [IDX_W-1:0]              req_r, req_c;
   logic [IDX_W-1:0]              up_r, dn_r, lf_c, rt_c;
   logic [isms_pkg::THR_IDX_W-1:0] entry;
   logic [isms_pkg::THR_W-1:0]    thr;
   logic                          flip, reject, do_write;

   // Sites off the lattice saturate to the last row or column.
   always_comb begin
      req_r = (req_bus.row > isms_pkg::COORD_W'(LATTICE_SIZE - 1)) ? LAST
            : req_bus.row[IDX_W-1:0];
      req_c = (req_bus.column > isms_pkg::COORD_W'(LATTICE_SIZE - 1)) ? LAST
            : req_bus.column[IDX_W-1:0];
   end

   always_comb begin
      up_r = (r_ff == '0)   ? LAST : r_ff - 1'b1;
      dn_r = (r_ff == LAST) ? '0   : r_ff + 1'b1;
      lf_c = (c_ff == '0)   ? LAST : c_ff - 1'b1;
      rt_c = (c_ff == LAST) ? '0   : c_ff + 1'b1;
   end

   // Shared neighbour accumulator: one row is folded in per read beat.
   always_comb begin
      cnt_in = cnt_ff;
      unique case (state_ff)
         isms_pkg::ST_RD_DN:  cnt_in = {{(isms_pkg::UPS_W-1){1'b0}}, rd_row[c_ff]};
         isms_pkg::ST_RD_CTR: cnt_in = cnt_ff + isms_pkg::UPS_W'(rd_row[c_ff]);
         isms_pkg::ST_CAPT:   cnt_in = cnt_ff + isms_pkg::UPS_W'(rd_row[lf_c])
                                              + isms_pkg::UPS_W'(rd_row[rt_c]);
         default:             cnt_in = cnt_ff;
      endcase
   end

   always_comb begin
      entry    = cur_ff ? isms_pkg::THR_UP_BASE + isms_pkg::THR_IDX_W'(cnt_ff)
                        : isms_pkg::THR_IDX_W'(cnt_ff);
      thr      = thr_table[entry];
      flip     = val_ff != cur_ff;
      reject   = (op_ff == isms_pkg::OP_TRIAL) && flip && (thr < toss_ff);
      do_write = (op_ff == isms_pkg::OP_WRITE)
              || ((op_ff == isms_pkg::OP_TRIAL) && flip && !reject);
      spin_in  = do_write ? val_ff : cur_ff;
      acc_in   = !reject;
      for (int i = 0; i < LATTICE_SIZE; i++) begin
         wr_row[i] = (IDX_W'(i) == c_ff) ? val_ff : row_ff[i];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         isms_pkg::ST_IDLE:   if (req_bus.valid) state_in = isms_pkg::ST_RD_UP;
         isms_pkg::ST_RD_UP:  state_in = isms_pkg::ST_RD_DN;
         isms_pkg::ST_RD_DN:  state_in = isms_pkg::ST_RD_CTR;
         isms_pkg::ST_RD_CTR: state_in = isms_pkg::ST_CAPT;
         isms_pkg::ST_CAPT:   state_in = isms_pkg::ST_DECIDE;
         isms_pkg::ST_DECIDE: state_in = isms_pkg::ST_DONE;
         isms_pkg::ST_DONE:   if (res_ready) state_in = isms_pkg::ST_IDLE;
         default:             state_in = isms_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = 1'b0;
      rd_addr       = r_ff;
      wr_en         = 1'b0;
      res_valid     = 1'b0;
      unique case (state_ff)
         isms_pkg::ST_IDLE:   req_bus.ready = 1'b1;
         isms_pkg::ST_RD_UP:  rd_addr = up_r;
         isms_pkg::ST_RD_DN:  rd_addr = dn_r;
         isms_pkg::ST_RD_CTR: rd_addr = r_ff;
         isms_pkg::ST_DECIDE: wr_en = do_write;
         isms_pkg::ST_DONE:   res_valid = 1'b1;
         default:             rd_addr = r_ff;
      endcase
   end

   assign wr_addr           = r_ff;
   assign res.spin          = spin_ff;
   assign res.accepted      = acc_ff;
   assign res.up_neighbours = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= isms_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      if (state_ff == isms_pkg::ST_IDLE && req_bus.valid) begin
         op_ff   <= req_bus.operation;
         r_ff    <= req_r;
         c_ff    <= req_c;
         val_ff  <= req_bus.spin_value;
         toss_ff <= req_bus.toss;
      end
      if (state_ff == isms_pkg::ST_CAPT) begin
         row_ff <= rd_row;
         cur_ff <= rd_row[c_ff];
      end
      if (state_ff == isms_pkg::ST_DECIDE) begin
         spin_ff <= spin_in;
         acc_ff  <= acc_in;
      end
   end

endmodule

[hw/rtl/ising_metropolis_site_update_top.sv]
// ----------------------------------------------------------------------------
// ising_metropolis_site_update_top
// Square torus of one-bit spins with write, read and Metropolis trial items.
//
// Usage: items arrive on req_bus (valid/ready); each gives exactly one beat
// on rsp_bus with the site spin after the item, the accept flag and the
// count of up-spin neighbours. Acceptance thresholds are written through the
// csr_ port (index 0 low, 1 mid, 2 high table word) while the block is idle;
// the block itself does not enforce this. A sequencer visits the single
// lattice read port once per row (upper, lower, own row), builds the
// neighbour count in one shared accumulator, then decides the item, and takes
// no new item until its result has moved to the output register.
// Reset: all spins read as -1 and every threshold is all ones (always
// accept); reset takes effect with no clearing pass.
// Stalls: a finished response waits in an output register, so the next item
// is taken while it waits; a second result holds until rsp_bus.ready.
// ----------------------------------------------------------------------------
module ising_metropolis_site_update_top #(
   parameter int LATTICE_SIZE = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   isms_req_if.sink                          req_bus,
   isms_rsp_if.source                        rsp_bus,
   input  logic                              csr_wr_en,
   input  logic [isms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [isms_pkg::CSR_W-1:0]        csr_wr_data
);

   localparam int IDX_W = (LATTICE_SIZE > 1) ? $clog2(LATTICE_SIZE) : 1;

   logic [63:0]             table_low_ff;
   logic [63:0]             table_mid_ff;
   logic [31:0]             table_high_ff;
   isms_pkg::thr_table_type thr_table;

   logic [IDX_W-1:0]        rd_addr, wr_addr;
   logic [LATTICE_SIZE-1:0] rd_row, wr_row;
   logic                    wr_en;
   logic                    res_valid, res_ready;
   isms_pkg::result_type    res;
   logic                    rsp_valid_ff;
   isms_pkg::result_type    rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_low_ff  <= '1;
         table_mid_ff  <= '1;
         table_high_ff <= '1;
      end else if (csr_wr_en) begin
         priority if (csr_index == isms_pkg::CSR_TABLE_LOW) begin
            table_low_ff <= csr_wr_data;
         end else if (csr_index == isms_pkg::CSR_TABLE_MID) begin
            table_mid_ff <= csr_wr_data;
         end else if (csr_index == isms_pkg::CSR_TABLE_HIGH) begin
            table_high_ff <= csr_wr_data[31:0];
         end else begin
            table_low_ff <= table_low_ff;
         end
      end
   end

   always_comb begin
      for (int e = 0; e < 4; e++) begin
         thr_table[e]     = table_low_ff[16*e +: 16];
         thr_table[e + 4] = table_mid_ff[16*e +: 16];
      end
      thr_table[8] = table_high_ff[15:0];
      thr_table[9] = table_high_ff[31:16];
   end

   isms_trial_ctrl #(
      .LATTICE_SIZE (LATTICE_SIZE),
      .IDX_W        (IDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .thr_table (thr_table),
      .rd_addr   (rd_addr),
      .rd_row    (rd_row),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_row    (wr_row),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   isms_lattice_mem #(
      .LATTICE_SIZE (LATTICE_SIZE),
      .IDX_W        (IDX_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_row  (rd_row),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_row  (wr_row)
   );

   // The output register frees up in the same cycle its beat is taken.
   assign res_ready = !rsp_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.spin          = rsp_data_ff.spin;
   assign rsp_bus.accepted      = rsp_data_ff.accepted;
   assign rsp_bus.up_neighbours = rsp_data_ff.up_neighbours;

endmodule
